### src/imuwfe_pkg.sv
// ----------------------------------------------------------------------------
// IMU window feature extractor: shared package
// Field widths, register indexes, feature codes and the status word that
// the iterative arithmetic units return to the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package imuwfe_pkg;

   // Fixed field widths of the ports.
   localparam int VALUE_W     = 49;
   localparam int INDEX_W     = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int WLEN_W      = 11;
   localparam int THRESH_W    = 32;

   // Features are scaled by two to the sixteenth.
   localparam int FRAC_W = 16;

   // Configuration register indexes and reset values.
   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_LENGTH    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CHANGE_THRESHOLD = 2'd1;
   localparam logic [WLEN_W-1:0]      WLEN_RESET           = 11'd50;
   localparam logic [THRESH_W-1:0]    THRESH_RESET         = 32'd655;

   // Feature codes past the per-axis group.
   localparam logic [INDEX_W-1:0] FEAT_ENERGY = 4'd9;
   localparam logic [INDEX_W-1:0] FEAT_CHANGE = 4'd10;
   localparam logic [INDEX_W-1:0] FEAT_RANGE  = 4'd11;

   // Kind of feature within one axis group.
   typedef enum logic [1:0] {
      KIND_MEAN,
      KIND_VAR,
      KIND_PEAK
   } feature_kind_type;

   // Status of an iterative unit.
   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

`default_nettype wire

### src/imuwfe_square.sv
// ----------------------------------------------------------------------------
// IMU window feature extractor: shared squarer
// One unsigned square per cycle with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module imuwfe_square #(
   parameter int OP_W = 32
) (
   input  wire logic              clock,
   input  wire logic [OP_W-1:0]   operand,
   output logic      [2*OP_W-1:0] product
);

   logic [2*OP_W-1:0] product_ff;

   // Register the product so the next use starts from a clean register.
   always_ff @(posedge clock) begin
      product_ff <= operand * operand;
   end

   assign product = product_ff;

endmodule

`default_nettype wire

### src/imuwfe_isqrt.sv
// ----------------------------------------------------------------------------
// IMU window feature extractor: iterative square root
// Floor square root, one result bit per cycle, digit by digit.
// ----------------------------------------------------------------------------
`default_nettype none

module imuwfe_isqrt #(
   parameter int SW = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [2*SW-1:0]                   radicand,
   output imuwfe_pkg::unit_status_type            status,
   output logic      [SW-1:0]                     root
);

   import imuwfe_pkg::*;

   localparam int CNT_W = $clog2(SW + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [2*SW-1:0]  rad_ff;
   logic [SW:0]      rem_ff;
   logic [SW-1:0]    root_ff;
   logic [SW+1:0]    rem_sh;
   logic [SW+1:0]    trial;
   logic             fits;

   // Bring down the next two radicand bits and try the next root bit.
   always_comb begin
      rem_sh = {rem_ff[SW-1:0], rad_ff[2*SW-1 -: 2]};
      trial  = {root_ff, 2'b01};
      fits   = rem_sh >= trial;
   end

   // Control: step count and done pulse.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(SW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: remainder and partial root.
   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= rad_ff << 2;
         rem_ff  <= fits ? (SW+1)'(rem_sh - trial) : (SW+1)'(rem_sh);
         root_ff <= {root_ff[SW-2:0], fits};
      end
   end

   assign status = '{busy: busy_ff, done: done_ff};
   assign root   = root_ff;

endmodule

`default_nettype wire

### src/imuwfe_div.sv
// ----------------------------------------------------------------------------
// IMU window feature extractor: iterative divider
// Unsigned restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module imuwfe_div #(
   parameter int DIVIDEND_W = 58,
   parameter int DIVISOR_W  = 11
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [DIVIDEND_W-1:0]     dividend,
   input  wire logic [DIVISOR_W-1:0]      divisor,
   output imuwfe_pkg::unit_status_type    status,
   output logic      [DIVIDEND_W-1:0]     quotient
);

   import imuwfe_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W-1:0]  div_ff;
   logic [DIVISOR_W:0]    rem_sh;
   logic                  fits;

   // Shift in the next dividend bit and try a subtract.
   always_comb begin
      rem_sh = {rem_ff, quo_ff[DIVIDEND_W-1]};
      fits   = rem_sh >= {1'b0, div_ff};
   end

   // Control: step count and done pulse.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIVIDEND_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: the dividend register fills with quotient bits from the bottom.
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], fits};
         rem_ff <= fits ? DIVISOR_W'(rem_sh - {1'b0, div_ff}) : DIVISOR_W'(rem_sh);
      end
   end

   assign status   = '{busy: busy_ff, done: done_ff};
   assign quotient = quo_ff;

endmodule

`default_nettype wire

### src/imu_window_feature_extractor_unit.sv
// ----------------------------------------------------------------------------
// IMU window feature extractor: top level
// Accumulates per-window accelerometer statistics and emits twelve scaled
// features at the end of each window.
//
//   Channel   Direction  Word
//   req_      in         one three-axis sample
//   rsp_      out        one feature (index, value, last flag)
//   csr_      in         one register write (index, data)
//
// A sample passes the shared squarer, then the floor square root,
// which yields one bit per cycle.
// A window end adds twelve features; mean, variance, energy and change
// rate each pass the bit-serial divider, and the output can stall.
// Reset is synchronous; it clears the window and loads the register defaults.
// req_ready is low while a sample or a window end is in work; a stalled
// feature word holds until taken. csr_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_window_feature_extractor_unit #(
   parameter int MAX_WINDOW   = 1024,
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic signed [SAMPLE_WIDTH-1:0]         req_accel_x,
   input  wire logic signed [SAMPLE_WIDTH-1:0]         req_accel_y,
   input  wire logic signed [SAMPLE_WIDTH-1:0]         req_accel_z,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic        [imuwfe_pkg::INDEX_W-1:0]       rsp_feature_index,
   output logic signed [imuwfe_pkg::VALUE_W-1:0]       rsp_feature_value,
   output logic                                        rsp_last_feature,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic   [imuwfe_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic   [imuwfe_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import imuwfe_pkg::*;

   localparam int SW      = SAMPLE_WIDTH;
   localparam int CW      = $clog2(MAX_WINDOW + 1);
   localparam int CCW     = $clog2(MAX_WINDOW);
   localparam int MW      = SW + 1;
   localparam int SUM_W   = SW + CW;
   localparam int SQ_W    = 2 * SW;
   localparam int SQS_W   = 2 * SW + CW - 1;
   localparam int DW      = SQS_W + FRAC_W;
   localparam int MULW    = SW + FRAC_W;
   localparam int PROD_W  = 2 * MULW;
   localparam int M2_W    = PROD_W - FRAC_W;
   localparam int VW      = ((DW > M2_W) ? DW : M2_W) + 1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQX,
      ST_SQY,
      ST_SQZ,
      ST_SQSUM,
      ST_ROOT,
      ST_DIFF,
      ST_CHANGE,
      ST_FEAT,
      ST_FDIV,
      ST_FMUL,
      ST_FVAR,
      ST_OUT
   } state_type;

   state_type               state_ff;
   logic [WLEN_W-1:0]       wlen_ff;
   logic [THRESH_W-1:0]     thresh_ff;

   logic signed [SUM_W-1:0] axis_sum_ff [0:2];
   logic [SQS_W-1:0]        axis_sqsum_ff [0:2];
   logic [SW-1:0]           axis_peak_ff [0:2];
   logic [SQS_W-1:0]        energy_ff;
   logic [MW-1:0]           mag_min_ff;
   logic [MW-1:0]           mag_max_ff;
   logic [MW-1:0]           prev_mag_ff;
   logic [MW-1:0]           mag_ff;
   logic [CCW-1:0]          change_ff;
   logic [CW-1:0]           cnt_ff;

   logic [SW-1:0]           abs_x_ff;
   logic [SW-1:0]           abs_y_ff;
   logic [SW-1:0]           abs_z_ff;
   logic [SQ_W-1:0]         sq_ff;

   logic [INDEX_W-1:0]      fidx_ff;
   logic [1:0]              axis_ff;
   feature_kind_type        kind_ff;
   logic [DW-1:0]           q_ff;
   logic [MULW-1:0]         mean_abs_ff;
   logic signed [VALUE_W-1:0] value_ff;

   logic [SW-1:0]           abs_x;
   logic [SW-1:0]           abs_y;
   logic [SW-1:0]           abs_z;
   logic [CW-1:0]           n_eff;
   logic [SQ_W-1:0]         sq_total;
   logic [MW-1:0]           mag_diff;
   logic [MULW-1:0]         mult_op;
   logic [PROD_W-1:0]       product;
   logic                    sqrt_start;
   unit_status_type         sqrt_status;
   logic [SW-1:0]           root;
   logic                    div_start;
   logic [DW-1:0]           div_dividend;
   logic [CW-1:0]           div_divisor;
   unit_status_type         div_status;
   logic [DW-1:0]           quotient;
   logic                    sum_neg;
   logic [SUM_W-1:0]        sum_abs;
   logic signed [DW:0]      q_signed;
   logic signed [DW:0]      mean_val;
   logic [VW-1:0]           var_a;
   logic [VW-1:0]           var_b;
   logic [VW-1:0]           var_val;
   logic                    per_axis;
   logic                    window_done;

   // Absolute sample values; the most negative code maps to its magnitude.
   assign abs_x = req_accel_x[SW-1] ? SW'(-req_accel_x) : SW'(req_accel_x);
   assign abs_y = req_accel_y[SW-1] ? SW'(-req_accel_y) : SW'(req_accel_y);
   assign abs_z = req_accel_z[SW-1] ? SW'(-req_accel_z) : SW'(req_accel_z);

   // Effective window length, clamped to the supported range.
   always_comb begin
      if (wlen_ff < WLEN_W'(2)) begin
         n_eff = CW'(2);
      end else if (32'(wlen_ff) > MAX_WINDOW) begin
         n_eff = CW'(MAX_WINDOW);
      end else begin
         n_eff = CW'(wlen_ff);
      end
   end

   assign sq_total    = sq_ff + product[SQ_W-1:0];
   assign mag_diff    = (mag_ff >= prev_mag_ff) ? mag_ff - prev_mag_ff : prev_mag_ff - mag_ff;
   assign window_done = (CW + 1)'(cnt_ff) + 1'b1 >= (CW + 1)'(n_eff);
   assign per_axis    = fidx_ff < FEAT_ENERGY;

   // Operand of the shared squarer, chosen by the sequencer step.
   always_comb begin
      case (state_ff)
         ST_SQX:  mult_op = MULW'(abs_x_ff);
         ST_SQY:  mult_op = MULW'(abs_y_ff);
         ST_SQZ:  mult_op = MULW'(abs_z_ff);
         ST_DIFF: mult_op = MULW'(mag_diff);
         ST_FMUL: mult_op = mean_abs_ff;
         default: mult_op = '0;
      endcase
   end

   // Divider operands for the current feature.
   always_comb begin
      sum_neg      = axis_sum_ff[axis_ff][SUM_W-1];
      sum_abs      = sum_neg ? SUM_W'(-axis_sum_ff[axis_ff]) : SUM_W'(axis_sum_ff[axis_ff]);
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = n_eff;
      if (state_ff == ST_FEAT) begin
         if (per_axis) begin
            case (kind_ff)
               KIND_MEAN: begin
                  div_start    = 1'b1;
                  div_dividend = DW'({sum_abs, {FRAC_W{1'b0}}});
               end
               KIND_VAR: begin
                  div_start    = 1'b1;
                  div_dividend = DW'({axis_sqsum_ff[axis_ff], {FRAC_W{1'b0}}});
               end
               default: div_start = 1'b0;
            endcase
         end else begin
            case (fidx_ff)
               FEAT_ENERGY: begin
                  div_start    = 1'b1;
                  div_dividend = DW'({energy_ff, {FRAC_W{1'b0}}});
               end
               FEAT_CHANGE: begin
                  div_start    = 1'b1;
                  div_dividend = DW'({change_ff, {FRAC_W{1'b0}}});
                  div_divisor  = n_eff - 1'b1;
               end
               default: div_start = 1'b0;
            endcase
         end
      end
   end

   // Signed mean and clamped variance from the divider and squarer results.
   always_comb begin
      q_signed = $signed({1'b0, quotient});
      mean_val = sum_neg ? -q_signed : q_signed;
      var_a    = VW'(q_ff);
      var_b    = VW'(product[PROD_W-1:FRAC_W]);
      var_val  = (var_a > var_b) ? var_a - var_b : '0;
   end

   assign sqrt_start = state_ff == ST_SQSUM;

   imuwfe_square #(
      .OP_W(MULW)
   ) u_square (
      .clock   (clock),
      .operand (mult_op),
      .product (product)
   );

   imuwfe_isqrt #(
      .SW(SW)
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sq_total),
      .status   (sqrt_status),
      .root     (root)
   );

   imuwfe_div #(
      .DIVIDEND_W(DW),
      .DIVISOR_W (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_status),
      .quotient (quotient)
   );

   // Sequencer, window state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         wlen_ff     <= WLEN_RESET;
         thresh_ff   <= THRESH_RESET;
         prev_mag_ff <= '0;
         for (int a = 0; a < 3; a++) begin
            axis_sum_ff[a]   <= '0;
            axis_sqsum_ff[a] <= '0;
            axis_peak_ff[a]  <= '0;
         end
         energy_ff  <= '0;
         mag_min_ff <= '1;
         mag_max_ff <= '0;
         change_ff  <= '0;
         cnt_ff     <= '0;
         fidx_ff    <= '0;
         axis_ff    <= '0;
         kind_ff    <= KIND_MEAN;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_WINDOW_LENGTH) begin
               wlen_ff <= csr_wdata[WLEN_W-1:0];
            end else if (csr_index == REG_CHANGE_THRESHOLD) begin
               thresh_ff <= csr_wdata[THRESH_W-1:0];
            end
         end

         case (state_ff)
            // Take a sample: sums and peaks update at once.
            ST_IDLE: begin
               if (req_valid) begin
                  abs_x_ff       <= abs_x;
                  abs_y_ff       <= abs_y;
                  abs_z_ff       <= abs_z;
                  axis_sum_ff[0] <= axis_sum_ff[0] + SUM_W'(req_accel_x);
                  axis_sum_ff[1] <= axis_sum_ff[1] + SUM_W'(req_accel_y);
                  axis_sum_ff[2] <= axis_sum_ff[2] + SUM_W'(req_accel_z);
                  if (abs_x > axis_peak_ff[0]) axis_peak_ff[0] <= abs_x;
                  if (abs_y > axis_peak_ff[1]) axis_peak_ff[1] <= abs_y;
                  if (abs_z > axis_peak_ff[2]) axis_peak_ff[2] <= abs_z;
                  state_ff <= ST_SQX;
               end
            end
            ST_SQX: state_ff <= ST_SQY;
            // Square results arrive in the step after their operand.
            ST_SQY: begin
               axis_sqsum_ff[0] <= axis_sqsum_ff[0] + SQS_W'(product[SQ_W-1:0]);
               sq_ff            <= product[SQ_W-1:0];
               state_ff         <= ST_SQZ;
            end
            ST_SQZ: begin
               axis_sqsum_ff[1] <= axis_sqsum_ff[1] + SQS_W'(product[SQ_W-1:0]);
               sq_ff            <= sq_total;
               state_ff         <= ST_SQSUM;
            end
            ST_SQSUM: begin
               axis_sqsum_ff[2] <= axis_sqsum_ff[2] + SQS_W'(product[SQ_W-1:0]);
               energy_ff        <= energy_ff + SQS_W'(sq_total);
               state_ff         <= ST_ROOT;
            end
            // Magnitude ready: track its extremes.
            ST_ROOT: begin
               if (sqrt_status.done) begin
                  mag_ff <= MW'(root);
                  if (MW'(root) < mag_min_ff) mag_min_ff <= MW'(root);
                  if (MW'(root) > mag_max_ff) mag_max_ff <= MW'(root);
                  state_ff <= ST_DIFF;
               end
            end
            ST_DIFF: state_ff <= ST_CHANGE;
            // Squared step against the threshold; the first sample never counts.
            ST_CHANGE: begin
               if (cnt_ff != '0 && product > PROD_W'(thresh_ff)) begin
                  change_ff <= change_ff + 1'b1;
               end
               prev_mag_ff <= mag_ff;
               cnt_ff      <= cnt_ff + 1'b1;
               if (window_done) begin
                  fidx_ff  <= '0;
                  axis_ff  <= '0;
                  kind_ff  <= KIND_MEAN;
                  state_ff <= ST_FEAT;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            // Start a feature: divide, or load a shifted value directly.
            ST_FEAT: begin
               if (div_start) begin
                  state_ff <= ST_FDIV;
               end else if (per_axis) begin
                  value_ff <= VALUE_W'({axis_peak_ff[axis_ff], {FRAC_W{1'b0}}});
                  state_ff <= ST_OUT;
               end else begin
                  value_ff <= VALUE_W'({mag_max_ff - mag_min_ff, {FRAC_W{1'b0}}});
                  state_ff <= ST_OUT;
               end
            end
            ST_FDIV: begin
               if (div_status.done) begin
                  if (per_axis && kind_ff == KIND_MEAN) begin
                     value_ff    <= VALUE_W'(mean_val);
                     mean_abs_ff <= MULW'(quotient);
                     state_ff    <= ST_OUT;
                  end else if (per_axis) begin
                     q_ff     <= quotient;
                     state_ff <= ST_FMUL;
                  end else begin
                     value_ff <= VALUE_W'(quotient);
                     state_ff <= ST_OUT;
                  end
               end
            end
            ST_FMUL: state_ff <= ST_FVAR;
            ST_FVAR: begin
               value_ff <= VALUE_W'(var_val);
               state_ff <= ST_OUT;
            end
            // Hold the feature word until taken, then step or close the window.
            ST_OUT: begin
               if (rsp_ready) begin
                  if (fidx_ff == FEAT_RANGE) begin
                     for (int a = 0; a < 3; a++) begin
                        axis_sum_ff[a]   <= '0;
                        axis_sqsum_ff[a] <= '0;
                        axis_peak_ff[a]  <= '0;
                     end
                     energy_ff  <= '0;
                     mag_min_ff <= '1;
                     mag_max_ff <= '0;
                     change_ff  <= '0;
                     cnt_ff     <= '0;
                     state_ff   <= ST_IDLE;
                  end else begin
                     fidx_ff <= fidx_ff + 1'b1;
                     case (kind_ff)
                        KIND_MEAN: kind_ff <= KIND_VAR;
                        KIND_VAR:  kind_ff <= KIND_PEAK;
                        default: begin
                           kind_ff <= KIND_MEAN;
                           axis_ff <= axis_ff + 1'b1;
                        end
                     endcase
                     state_ff <= ST_FEAT;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready         = state_ff == ST_IDLE;
   assign rsp_valid         = state_ff == ST_OUT;
   assign rsp_feature_index = fidx_ff;
   assign rsp_feature_value = value_ff;
   assign rsp_last_feature  = fidx_ff == FEAT_RANGE;
   assign csr_ready         = 1'b1;

   // A feature word on the output never overlaps sample intake.
   a_rsp_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("sample accepted while a feature word is pending");

   // Once a window holds samples, the magnitude extremes are ordered.
   a_mag_order: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != '0 |-> mag_max_ff >= mag_min_ff)
      else $error("magnitude max below min in an open window");

   // An empty window has no counted changes.
   a_change_empty: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == '0 |-> change_ff == '0)
      else $error("change count nonzero in an empty window");

   // The divider only runs while the sequencer waits on it.
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> state_ff == ST_FDIV)
      else $error("divider busy outside its wait step");

endmodule

`default_nettype wire

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// IMU window feature extractor: testbench
// Sends three-axis samples through the request channel and checks every
// feature word against a window-statistics predictor kept in the bench.
// A short table of directed samples and register writes comes first, then
// random windows under three idling patterns. The random part includes one
// long receiver stall and a short run under a window length past the limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
   import imuwfe_pkg::*;

   localparam int MAX_WIN    = 1024;
   localparam int SCALE_LOG  = 16;
   localparam int SETTLE     = 400;
   localparam int STALL_MAX  = 5000;

   typedef enum logic {ROW_SAMPLE, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type             kind;
      logic signed [15:0]       x, y, z;
      logic [CSR_INDEX_W-1:0]   reg_index;
      logic [CSR_DATA_W-1:0]    reg_data;
      bit                       typed;
      logic [INDEX_W-1:0]       typed_index;
      logic signed [VALUE_W-1:0] typed_value;
   } stim_row_type;

   typedef struct {
      logic [INDEX_W-1:0]        index;
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } feature_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [15:0] req_accel_x = '0, req_accel_y = '0, req_accel_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [INDEX_W-1:0] rsp_feature_index;
   logic signed [VALUE_W-1:0] rsp_feature_value;
   logic rsp_last_feature;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   imu_window_feature_extractor_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_accel_x(req_accel_x), .req_accel_y(req_accel_y), .req_accel_z(req_accel_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_feature_index(rsp_feature_index), .rsp_feature_value(rsp_feature_value),
      .rsp_last_feature(rsp_last_feature),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Predictor state: registers and the running window.
   logic [WLEN_W-1:0]   win_length;
   logic [THRESH_W-1:0] step_threshold;
   longint              sum_axis [3];
   longint unsigned     sum_sq_axis [3];
   longint unsigned     peak_axis [3];
   longint unsigned     energy_acc;
   longint unsigned     mag_low, mag_high, mag_prev;
   int                  steps_over, samples_in;

   feature_type pending_features[$];
   feature_type hand_values[$];

   int  error_count = 0;
   int  samples_sent = 0;
   int  features_seen = 0;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  hold_request = 0;
   bit  finished = 0;

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r = 0;
      longint unsigned b = 64'h4000_0000_0000_0000;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function void clear_window();
      for (int a = 0; a < 3; a++) begin
         sum_axis[a] = 0;
         sum_sq_axis[a] = 0;
         peak_axis[a] = 0;
      end
      energy_acc = 0;
      mag_low = 64'h1FFFF;
      mag_high = 0;
      steps_over = 0;
      samples_in = 0;
   endfunction

   function void queue_feature(int k, longint v);
      feature_type f;
      f.index = k[INDEX_W-1:0];
      f.value = v[VALUE_W-1:0];
      f.last  = (k == FEAT_RANGE);
      pending_features.push_back(f);
   endfunction

   // Fold one sample into the window; on a window end, queue twelve features.
   function void absorb_sample(logic signed [15:0] sx, logic signed [15:0] sy,
                               logic signed [15:0] sz);
      longint s [3];
      longint unsigned m, sq, mag, d2;
      longint n, mean, msq, spread, d;
      s[0] = sx; s[1] = sy; s[2] = sz;
      sq = 0;
      for (int a = 0; a < 3; a++) begin
         m = (s[a] < 0) ? -s[a] : s[a];
         sum_axis[a] += s[a];
         sum_sq_axis[a] += m * m;
         if (m > peak_axis[a]) peak_axis[a] = m;
         sq += m * m;
      end
      energy_acc += sq;
      mag = floor_sqrt(sq) & 64'h1FFFF;
      if (mag < mag_low) mag_low = mag;
      if (mag > mag_high) mag_high = mag;
      // The first sample of a window is never compared with the last one.
      if (samples_in > 0) begin
         d = longint'(mag) - longint'(mag_prev);
         d2 = d * d;
         if (d2 > step_threshold) steps_over++;
      end
      mag_prev = mag;
      samples_in++;
      n = win_length;
      if (n < 2) n = 2;
      if (n > MAX_WIN) n = MAX_WIN;
      if (samples_in < n) return;
      for (int a = 0; a < 3; a++) begin
         mean = (sum_axis[a] <<< SCALE_LOG) / n;
         msq = longint'((sum_sq_axis[a] << SCALE_LOG) / longint'(n));
         spread = msq - (mean * mean) / (64'sd1 <<< SCALE_LOG);
         if (spread < 0) spread = 0;
         queue_feature(a * 3 + KIND_MEAN, mean);
         queue_feature(a * 3 + KIND_VAR, spread);
         queue_feature(a * 3 + KIND_PEAK, longint'(peak_axis[a]) <<< SCALE_LOG);
      end
      queue_feature(FEAT_ENERGY, longint'((energy_acc << SCALE_LOG) / longint'(n)));
      queue_feature(FEAT_CHANGE, (longint'(steps_over) <<< SCALE_LOG) / (n - 1));
      queue_feature(FEAT_RANGE,
                    (longint'(mag_high) - longint'(mag_low)) <<< SCALE_LOG);
      clear_window();
   endfunction

   // Monitor: follows each handshake at the edge where it completes.
   always @(posedge clock) begin
      int before_count;
      feature_type e, h;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_WINDOW_LENGTH) win_length = csr_wdata[WLEN_W-1:0];
            else if (csr_index == REG_CHANGE_THRESHOLD) step_threshold = csr_wdata;
         end
         if (req_valid && req_ready) begin
            before_count = pending_features.size();
            absorb_sample(req_accel_x, req_accel_y, req_accel_z);
            samples_sent++;
            // Hand-typed values from the table are checked against the prediction.
            if (pending_features.size() > before_count && hand_values.size() > 0) begin
               h = hand_values.pop_front();
               e = pending_features[before_count + h.index];
               if (e.value !== h.value) begin
                  $display("%0t: feature %0d of table window: expected %0d, predicted %0d",
                           $time, h.index, h.value, e.value);
                  error_count++;
               end
            end
         end
         if (rsp_valid && rsp_ready) begin
            features_seen++;
            if (pending_features.size() == 0) begin
               $display("%0t: unexpected feature word: index %0d value %0d",
                        $time, rsp_feature_index, rsp_feature_value);
               error_count++;
            end else begin
               e = pending_features.pop_front();
               if (rsp_feature_index !== e.index) begin
                  $display("%0t: feature_index expected %0d, actual %0d",
                           $time, e.index, rsp_feature_index);
                  error_count++;
               end
               if (rsp_feature_value !== e.value) begin
                  $display("%0t: feature_value (index %0d) expected %0d, actual %0d",
                           $time, e.index, e.value, rsp_feature_value);
                  error_count++;
               end
               if (rsp_last_feature !== e.last) begin
                  $display("%0t: last_feature expected %0b, actual %0b",
                           $time, e.last, rsp_last_feature);
                  error_count++;
               end
            end
         end
      end
   end

   // Receiver: random ready, with one long hold-off on request.
   always @(posedge clock) begin
      if (hold_request) begin
         rsp_ready <= 1'b0;
         repeat (600) @(posedge clock);
         hold_request = 0;
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog: ends the run after too long without any handshake.
   always @(posedge clock) begin
      int quiet;
      if (reset || finished || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= STALL_MAX) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_MAX);
            $display("tb_top: errors");
            $finish;
         end
      end
   end

   // Offer one sample word, after a random gap.
   task automatic send_word(logic signed [15:0] x, logic signed [15:0] y,
                            logic signed [15:0] z);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_accel_x <= x;
      req_accel_y <= y;
      req_accel_z <= z;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Let all expected features arrive and the block go idle.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_features.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Random sample: mostly steady motion with jitter, some full range, some extremes.
   task automatic random_word(int base_x, int base_y, int base_z, int jitter);
      logic signed [15:0] v [3];
      int pick;
      pick = $urandom_range(9);
      for (int a = 0; a < 3; a++) begin
         if (pick < 6) begin
            v[a] = 16'(((a == 0) ? base_x : (a == 1) ? base_y : base_z)
                       + $signed($urandom_range(2 * jitter)) - jitter);
         end else if (pick < 9) begin
            v[a] = 16'($urandom);
         end else begin
            v[a] = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         end
      end
      send_word(v[0], v[1], v[2]);
   endtask

   task automatic random_phase(int count, int wlen, logic [31:0] thresh);
      int bx, by, bz, jit;
      settle();
      write_register(REG_WINDOW_LENGTH, wlen);
      write_register(REG_CHANGE_THRESHOLD, thresh);
      for (int i = 0; i < count; i++) begin
         if (i % 16 == 0) begin
            bx = $signed($urandom_range(8000)) - 4000;
            by = $signed($urandom_range(8000)) - 4000;
            bz = $signed($urandom_range(8000)) - 4000;
            jit = $urandom_range(1) ? 8 : 600;
         end
         random_word(bx, by, bz, jit);
      end
   endtask

   stim_row_type table_rows [$];

   function automatic stim_row_type sample_row(int x, int y, int z);
      stim_row_type r;
      r.kind = ROW_SAMPLE;
      r.x = 16'(x); r.y = 16'(y); r.z = 16'(z);
      r.reg_index = '0; r.reg_data = '0;
      r.typed = 0; r.typed_index = '0; r.typed_value = '0;
      return r;
   endfunction

   function automatic stim_row_type checked_row(int x, int y, int z,
                                                logic [INDEX_W-1:0] k, longint v);
      stim_row_type r;
      r = sample_row(x, y, z);
      r.typed = 1;
      r.typed_index = k;
      r.typed_value = v[VALUE_W-1:0];
      return r;
   endfunction

   function automatic stim_row_type csr_row(logic [CSR_INDEX_W-1:0] idx, logic [31:0] d);
      stim_row_type r;
      r = sample_row(0, 0, 0);
      r.kind = ROW_CSR;
      r.reg_index = idx;
      r.reg_data = d;
      return r;
   endfunction

   initial begin
      feature_type h;
      win_length = WLEN_RESET;
      step_threshold = THRESH_RESET;
      mag_prev = 0;
      clear_window();

      // A window length of zero acts as two; a zero threshold counts any step.
      table_rows.push_back(csr_row(REG_WINDOW_LENGTH, 0));
      table_rows.push_back(csr_row(REG_CHANGE_THRESHOLD, 0));
      table_rows.push_back(sample_row(0, 0, 0));
      table_rows.push_back(checked_row(0, 0, 0, FEAT_RANGE, 0));
      table_rows.push_back(sample_row(32767, 32767, 32767));
      table_rows.push_back(checked_row(-32768, -32768, -32768, 4'd2, 64'sd32768 <<< 16));
      table_rows.push_back(sample_row(-32768, 0, 32767));
      table_rows.push_back(checked_row(32767, -32768, 0, 4'd5, 64'sd32768 <<< 16));
      table_rows.push_back(sample_row(1, 0, 0));
      table_rows.push_back(checked_row(2, 0, 0, FEAT_CHANGE, 65536));
      // A step can never exceed the largest threshold.
      table_rows.push_back(csr_row(REG_CHANGE_THRESHOLD, 32'hFFFF_FFFF));
      table_rows.push_back(sample_row(0, 0, 0));
      table_rows.push_back(checked_row(32767, 32767, 32767, FEAT_CHANGE, 0));
      // Lower the window length mid-window: the next sample closes it.
      table_rows.push_back(csr_row(REG_WINDOW_LENGTH, 50));
      table_rows.push_back(csr_row(REG_CHANGE_THRESHOLD, 655));
      for (int i = 0; i < 5; i++) table_rows.push_back(sample_row(100 * i, -50 * i, 256));
      table_rows.push_back(csr_row(REG_WINDOW_LENGTH, 3));
      table_rows.push_back(sample_row(7, -7, 7));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (table_rows[i]) begin
         if (table_rows[i].kind == ROW_CSR) begin
            settle();
            write_register(table_rows[i].reg_index, table_rows[i].reg_data);
         end else begin
            if (table_rows[i].typed) begin
               h.index = table_rows[i].typed_index;
               h.value = table_rows[i].typed_value;
               h.last  = 1'b0;
               hand_values.push_back(h);
            end
            send_word(table_rows[i].x, table_rows[i].y, table_rows[i].z);
         end
      end

      // Random windows under the three idling patterns.
      send_idle_pct = 34; recv_idle_pct = 71;
      random_phase(60, $urandom_range(2, 6), $urandom_range(0, 4000));
      send_idle_pct = 71; recv_idle_pct = 34;
      random_phase(60, 1, $urandom_range(0, 200000));
      send_idle_pct = 0; recv_idle_pct = 0;
      settle();
      write_register(REG_WINDOW_LENGTH, 4);
      hold_request = 1;
      for (int i = 0; i < 60; i++) random_word(1000, -2000, 3000, 400);
      // A length past the limit acts as the limit, so a short run never closes.
      random_phase(20, 2047, 32'd655);

      settle();
      finished = 1;
      $display("Covered %0d samples and %0d feature words over short windows and",
               samples_sent, features_seen);
      $display("a length past the limit, full-scale thresholds, idle, stall and hold-off.");
      if (error_count == 0 && pending_features.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
